[src/pfba_pkg.sv]
// Package for the paged fixed block allocator: sizes, status codes, word types.
// No dependencies.
`default_nettype none
package pfba_pkg;
    localparam int MAX_PAGES  = 16;
    localparam int MAX_BLOCKS = 512;
    localparam int PW = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
    localparam int BW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int TOTAL = MAX_PAGES * MAX_BLOCKS;
    localparam int AW = PW + BW;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_OOM     = 2'd1;
    localparam logic [1:0] ST_INVALID = 2'd2;
    localparam logic [1:0] ST_DOUBLE  = 2'd3;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef struct packed {
        logic        operation;
        logic [12:0] block_handle;
    } t_in_word;

    typedef struct packed {
        logic [12:0] result_handle;
        logic [1:0]  status;
        logic [13:0] blocks_in_use;
        logic [4:0]  pages_open;
    } t_out_word;

    typedef struct packed {
        logic          we;
        logic [AW-1:0] addr;
        logic [BW-1:0] link;
        logic          is_end;
        logic          is_free;
    } t_mem_req;

    typedef struct packed {
        logic [BW-1:0] link;
        logic          is_end;
        logic          is_free;
    } t_mem_rd;
endpackage
`default_nettype wire

[src/pfba_if.sv]
// Valid/ready channel interfaces for input and result words.
// Depends on pfba_pkg.
`default_nettype none
interface pfba_in_if;
    logic               valid;
    logic               ready;
    pfba_pkg::t_in_word data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface pfba_out_if;
    logic                valid;
    logic                ready;
    pfba_pkg::t_out_word data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

[src/paged_fixed_block_allocator_core.sv]
// Top level of the paged fixed block allocator: page table, sequencer, output register.
// Depends on pfba_pkg, pfba_if, pfba_link_mem.
// Result is valid in the cycle after accept for bump/open allocs, invalid handle and OOM;
// frees and free-list allocs go through the steps accept, memory read, update.
// A new word is accepted only when idle and the previous result has left the output register.
// Reset: synchronous active low; page 0 open, counters cleared, block memory not cleared.
`default_nettype none
module paged_fixed_block_allocator_core (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_cfg_we,
    input  wire [9:0]        i_cfg_data,
    pfba_in_if.sink          in_ch,
    pfba_out_if.source       out_ch
);
    localparam int PW = pfba_pkg::PW;
    localparam int BW = pfba_pkg::BW;
    localparam int AW = pfba_pkg::AW;
    localparam int NP = pfba_pkg::MAX_PAGES;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_UPD  = 2'd2;

    logic [9:0]    r_bpp;
    logic [BW:0]   r_bump [NP];
    logic [BW-1:0] r_head [NP];
    logic [NP-1:0] r_hvalid;
    logic [PW:0]   r_pages;
    logic [13:0]   r_live;
    logic [1:0]    r_state;
    logic          r_op;
    logic [12:0]   r_h;
    logic [PW-1:0] r_pg;
    logic [BW-1:0] r_blk;
    logic          r_ovalid;
    pfba_pkg::t_out_word r_odata;

    pfba_pkg::t_mem_req mem_req;
    pfba_pkg::t_mem_rd  mem_rd;

    pfba_link_mem u_mem (.i_clk(i_clk), .i_req(mem_req), .o_rd(mem_rd));

    // effective blocks per page
    logic [BW:0] bpp_eff;
    always_comb begin
        if (r_bpp == 10'd0) bpp_eff = (BW+1)'(1);
        else if ({22'd0, r_bpp} > pfba_pkg::MAX_BLOCKS) bpp_eff = (BW+1)'(pfba_pkg::MAX_BLOCKS);
        else bpp_eff = (BW+1)'(r_bpp);
    end

    // find-first scans over open pages
    logic          bump_hit, free_hit;
    logic [PW-1:0] bump_pg, free_pg;
    always_comb begin
        bump_hit = 1'b0; free_hit = 1'b0;
        bump_pg = '0;    free_pg = '0;
        for (int p = NP - 1; p >= 0; p--) begin
            if ((PW+1)'(p) < r_pages && r_bump[p] < bpp_eff) begin
                bump_hit = 1'b1; bump_pg = PW'(p);
            end
            if ((PW+1)'(p) < r_pages && r_hvalid[p]) begin
                free_hit = 1'b1; free_pg = PW'(p);
            end
        end
    end

    wire           in_fire = in_ch.valid && in_ch.ready;
    wire [PW-1:0]  in_pg   = in_ch.data.block_handle[AW-1:BW];
    wire [BW-1:0]  in_blk  = in_ch.data.block_handle[BW-1:0];
    wire           in_pg_ok = {1'b0, in_pg} < r_pages && (13'(in_ch.data.block_handle) >> BW) < NP;
    wire           can_open = r_pages < (PW+1)'(NP);

    // ready only when idle and output register is free
    assign in_ch.ready = (r_state == S_IDLE) && !r_ovalid;
    assign out_ch.valid = r_ovalid;
    assign out_ch.data  = r_odata;

    always_comb begin
        mem_req = '0;
        mem_req.addr = {r_pg, r_blk};
        if (r_state == S_IDLE) mem_req.addr = {free_pg, r_head[free_pg]};
        if (r_state == S_IDLE && in_fire) begin
            if (in_ch.data.operation == pfba_pkg::OP_FREE) begin
                mem_req.addr = {in_pg, in_blk};
            end else if (bump_hit) begin
                mem_req.we = 1'b1;
                mem_req.addr = {bump_pg, r_bump[bump_pg][BW-1:0]};
            end else if (!free_hit && can_open) begin
                mem_req.we = 1'b1;
                mem_req.addr = {r_pages[PW-1:0], {BW{1'b0}}};
            end
        end
        if (r_state == S_UPD && r_op == pfba_pkg::OP_FREE && !mem_rd.is_free) begin
            mem_req.we = 1'b1;
            mem_req.link = r_head[r_pg];
            mem_req.is_end = !r_hvalid[r_pg];
            mem_req.is_free = 1'b1;
        end
        if (r_state == S_UPD && r_op == pfba_pkg::OP_ALLOC) begin
            mem_req.we = 1'b1;
            mem_req.link = mem_rd.link;
            mem_req.is_end = mem_rd.is_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bpp <= 10'd512;
            r_hvalid <= '0;
            r_pages <= (PW+1)'(1);
            r_live <= '0;
            r_state <= S_IDLE;
            r_ovalid <= 1'b0;
            for (int p = 0; p < NP; p++) begin
                r_bump[p] <= '0;
                r_head[p] <= '0;
            end
        end else begin
            if (i_cfg_we) r_bpp <= i_cfg_data;
            if (r_ovalid && out_ch.ready) r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_op <= in_ch.data.operation;
                        r_h <= in_ch.data.block_handle;
                        r_pg <= in_pg;
                        r_blk <= in_blk;
                        if (in_ch.data.operation == pfba_pkg::OP_FREE) begin
                            if (!in_pg_ok || {1'b0, in_blk} >= r_bump[in_pg]) begin
                                r_odata <= '{result_handle: in_ch.data.block_handle,
                                    status: pfba_pkg::ST_INVALID, blocks_in_use: r_live,
                                    pages_open: 5'(r_pages)};
                                r_ovalid <= 1'b1;
                            end else begin
                                r_state <= S_READ;
                            end
                        end else if (bump_hit) begin
                            r_bump[bump_pg] <= r_bump[bump_pg] + 1'b1;
                            r_live <= r_live + 1'b1;
                            r_odata <= '{result_handle: 13'({bump_pg,
                                r_bump[bump_pg][BW-1:0]}), status: pfba_pkg::ST_OK,
                                blocks_in_use: r_live + 1'b1, pages_open: 5'(r_pages)};
                            r_ovalid <= 1'b1;
                        end else if (free_hit) begin
                            r_pg <= free_pg;
                            r_blk <= r_head[free_pg];
                            r_state <= S_READ;
                        end else if (can_open) begin
                            r_bump[r_pages[PW-1:0]] <= (BW+1)'(1);
                            r_hvalid[r_pages[PW-1:0]] <= 1'b0;
                            r_head[r_pages[PW-1:0]] <= '0;
                            r_pages <= r_pages + 1'b1;
                            r_live <= r_live + 1'b1;
                            r_odata <= '{result_handle: 13'({r_pages[PW-1:0], {BW{1'b0}}}),
                                status: pfba_pkg::ST_OK, blocks_in_use: r_live + 1'b1,
                                pages_open: 5'(r_pages + 1'b1)};
                            r_ovalid <= 1'b1;
                        end else begin
                            r_odata <= '{result_handle: 13'd0, status: pfba_pkg::ST_OOM,
                                blocks_in_use: r_live, pages_open: 5'(r_pages)};
                            r_ovalid <= 1'b1;
                        end
                    end
                end
                S_READ: r_state <= S_UPD;
                S_UPD: begin
                    r_state <= S_IDLE;
                    r_ovalid <= 1'b1;
                    if (r_op == pfba_pkg::OP_ALLOC) begin
                        if (mem_rd.is_end) begin
                            r_hvalid[r_pg] <= 1'b0;
                            r_head[r_pg] <= '0;
                        end else begin
                            r_head[r_pg] <= mem_rd.link;
                        end
                        r_live <= r_live + 1'b1;
                        r_odata <= '{result_handle: 13'({r_pg, r_blk}),
                            status: pfba_pkg::ST_OK, blocks_in_use: r_live + 1'b1,
                            pages_open: 5'(r_pages)};
                    end else if (mem_rd.is_free) begin
                        r_odata <= '{result_handle: r_h, status: pfba_pkg::ST_DOUBLE,
                            blocks_in_use: r_live, pages_open: 5'(r_pages)};
                    end else begin
                        r_head[r_pg] <= r_blk;
                        r_hvalid[r_pg] <= 1'b1;
                        r_live <= (r_live != 14'd0) ? r_live - 1'b1 : r_live;
                        r_odata <= '{result_handle: r_h, status: pfba_pkg::ST_OK,
                            blocks_in_use: (r_live != 14'd0) ? r_live - 1'b1 : r_live,
                            pages_open: 5'(r_pages)};
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_pages_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pages >= (PW+1)'(1) && r_pages <= (PW+1)'(NP)) else $error("pages out of range");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !in_ch.ready) else $error("accept while busy");
    a_upd_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPD) |=> r_ovalid) else $error("update gave no result");
endmodule
`default_nettype wire

[src/pfba_link_mem.sv]
// Block memory: free-list link, end flag and free flag per block.
// Synchronous, registered read. Depends on pfba_pkg.
`default_nettype none
module pfba_link_mem (
    input  wire                  i_clk,
    input  wire pfba_pkg::t_mem_req i_req,
    output pfba_pkg::t_mem_rd    o_rd
);
    pfba_pkg::t_mem_rd r_mem [pfba_pkg::TOTAL];

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.addr] <= '{link: i_req.link, is_end: i_req.is_end,
                                   is_free: i_req.is_free};
        end
        o_rd <= r_mem[i_req.addr];
    end
endmodule
`default_nettype wire

[bench/tb.sv]
// Self-checking bench for paged_fixed_block_allocator_core: directed table, directed sequences, then
// random alloc/free traffic checked against an allocator predictor. Depends on pfba_pkg, pfba_if.
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;
    localparam int N_RANDOM = 1100;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_cfg_we = 1'b0;
    logic [9:0] i_cfg_data = '0;

    pfba_in_if  in_ch ();
    pfba_out_if out_ch ();

    paged_fixed_block_allocator_core u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .in_ch(in_ch.sink), .out_ch(out_ch.source)
    );

    always #6 i_clk = ~i_clk;

    // predictor state
    int unsigned bpp_reg;
    int unsigned bump[pfba_pkg::MAX_PAGES];
    int unsigned fhead[pfba_pkg::MAX_PAGES];
    bit          fhead_ok[pfba_pkg::MAX_PAGES];
    int unsigned link_mem[pfba_pkg::TOTAL];
    bit          link_end[pfba_pkg::TOTAL];
    bit          blk_free[pfba_pkg::TOTAL];
    int unsigned pages_used;
    int unsigned live_cnt;

    pfba_pkg::t_out_word expected_words[$];
    int        errors = 0;
    int        cycles = 0;
    bit        rx_hold = 1'b0;
    int        alloc_bias = 60;

    function automatic void alloc_reset();
        bpp_reg = 512;
        for (int p = 0; p < pfba_pkg::MAX_PAGES; p++) begin
            bump[p] = 0; fhead[p] = 0; fhead_ok[p] = 0;
        end
        for (int i = 0; i < pfba_pkg::TOTAL; i++) begin
            link_mem[i] = 0; link_end[i] = 0; blk_free[i] = 0;
        end
        pages_used = 1;
        live_cnt = 0;
    endfunction

    function automatic pfba_pkg::t_out_word alloc_predict(pfba_pkg::t_in_word w);
        pfba_pkg::t_out_word r;
        int unsigned bpp, idx, pg, bk;
        bit done;
        r = '0;
        done = 0;
        bpp = (bpp_reg == 0) ? 1 :
              (bpp_reg > pfba_pkg::MAX_BLOCKS ? pfba_pkg::MAX_BLOCKS : bpp_reg);
        if (w.operation == pfba_pkg::OP_ALLOC) begin
            for (int p = 0; p < pages_used && !done; p++) begin
                if (bump[p] < bpp) begin
                    idx = p * pfba_pkg::MAX_BLOCKS + bump[p];
                    blk_free[idx] = 0; bump[p]++;
                    r.result_handle = 13'(idx); done = 1;
                end
            end
            for (int p = 0; p < pages_used && !done; p++) begin
                if (fhead_ok[p]) begin
                    idx = p * pfba_pkg::MAX_BLOCKS + fhead[p];
                    if (link_end[idx]) begin
                        fhead_ok[p] = 0; fhead[p] = 0;
                    end else begin
                        fhead[p] = link_mem[idx];
                    end
                    blk_free[idx] = 0;
                    r.result_handle = 13'(idx); done = 1;
                end
            end
            if (!done) begin
                if (pages_used < pfba_pkg::MAX_PAGES) begin
                    pg = pages_used;
                    bump[pg] = 1; fhead_ok[pg] = 0; fhead[pg] = 0;
                    idx = pg * pfba_pkg::MAX_BLOCKS;
                    blk_free[idx] = 0;
                    r.result_handle = 13'(idx);
                    pages_used++; done = 1;
                end else begin
                    r.status = pfba_pkg::ST_OOM;
                end
            end
            if (done) live_cnt++;
        end else begin
            pg = w.block_handle / pfba_pkg::MAX_BLOCKS;
            bk = w.block_handle % pfba_pkg::MAX_BLOCKS;
            r.result_handle = w.block_handle;
            if (pg >= pages_used || bk >= bump[pg]) begin
                r.status = pfba_pkg::ST_INVALID;
            end else begin
                idx = w.block_handle;
                if (blk_free[idx]) begin
                    r.status = pfba_pkg::ST_DOUBLE;
                end else begin
                    link_mem[idx] = fhead_ok[pg] ? fhead[pg] : 0;
                    link_end[idx] = !fhead_ok[pg];
                    fhead[pg] = bk; fhead_ok[pg] = 1; blk_free[idx] = 1;
                    if (live_cnt > 0) live_cnt--;
                end
            end
        end
        r.blocks_in_use = 14'(live_cnt);
        r.pages_open = 5'(pages_used);
        return r;
    endfunction

    function automatic int short_or_long_gap();
        if ($urandom_range(0, 99) < 60) return 0;
        if ($urandom_range(0, 99) < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_word(pfba_pkg::t_in_word w, bit has_typed,
                             pfba_pkg::t_out_word typed);
        pfba_pkg::t_out_word pred;
        pred = alloc_predict(w);
        if (has_typed && typed != pred)
            $display("%0t table row disagrees with predictor: table %h predictor %h",
                     $time, typed, pred);
        expected_words.push_back(has_typed ? typed : pred);
        in_ch.valid = 1'b1;
        in_ch.data = w;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic gap_then_idle(int n);
        if (n > 0) begin
            in_ch.valid = 1'b0;
            repeat (n) @(negedge i_clk);
        end
    endtask

    task automatic drain_and_write(logic [9:0] v);
        in_ch.valid = 1'b0;
        while (expected_words.size() != 0) @(negedge i_clk);
        repeat (6) @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        bpp_reg = v;
    endtask

    function automatic pfba_pkg::t_in_word mk(logic op, int unsigned h);
        pfba_pkg::t_in_word w;
        w.operation = op;
        w.block_handle = h[12:0];
        return w;
    endfunction

    function automatic pfba_pkg::t_out_word ow(int unsigned h, logic [1:0] st,
                                               int unsigned n, int unsigned p);
        pfba_pkg::t_out_word r;
        r.result_handle = h[12:0]; r.status = st;
        r.blocks_in_use = n[13:0]; r.pages_open = p[4:0];
        return r;
    endfunction

    function automatic pfba_pkg::t_in_word random_word();
        int unsigned pg, bk;
        if ($urandom_range(0, 99) < alloc_bias) return mk(pfba_pkg::OP_ALLOC, $urandom);
        if ($urandom_range(0, 99) < 15)
            return mk(pfba_pkg::OP_FREE, $urandom_range(0, 8191));
        pg = $urandom_range(0, pages_used - 1);
        if (bump[pg] == 0) return mk(pfba_pkg::OP_FREE, pg * pfba_pkg::MAX_BLOCKS);
        bk = $urandom_range(0, bump[pg] - 1);
        return mk(pfba_pkg::OP_FREE, pg * pfba_pkg::MAX_BLOCKS + bk);
    endfunction

    // result side
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (out_ch.valid && out_ch.ready) begin
            if (expected_words.size() == 0) begin
                $display("%0t unexpected word %h", $time, out_ch.data);
                errors <= errors + 1;
            end else begin
                pfba_pkg::t_out_word e;
                e = expected_words.pop_front();
                if (e.result_handle != out_ch.data.result_handle ||
                    e.status != out_ch.data.status ||
                    e.blocks_in_use != out_ch.data.blocks_in_use ||
                    e.pages_open != out_ch.data.pages_open) begin
                    $display({"%0t mismatch: expected h=%0d st=%0d n=%0d p=%0d",
                              " actual h=%0d st=%0d n=%0d p=%0d"},
                             $time, e.result_handle, e.status, e.blocks_in_use,
                             e.pages_open, out_ch.data.result_handle, out_ch.data.status,
                             out_ch.data.blocks_in_use, out_ch.data.pages_open);
                    errors <= errors + 1;
                end
            end
        end
    end

    initial begin
        int g;
        out_ch.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (rx_hold) begin
                out_ch.ready <= 1'b0;
                repeat (120) @(negedge i_clk);
                rx_hold = 1'b0;
            end
            g = short_or_long_gap();
            if (g > 0) begin
                out_ch.ready <= 1'b0;
                repeat (g - 1) @(negedge i_clk);
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (cycles > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        pfba_pkg::t_in_word  dir_in[$];
        pfba_pkg::t_out_word dir_out[$];
        bit                  dir_typed[$];
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        alloc_reset();
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed table at reset value 512
        dir_in.push_back(mk(pfba_pkg::OP_FREE, 0));
        dir_out.push_back(ow(0, pfba_pkg::ST_INVALID, 0, 1));
        dir_typed.push_back(1);
        dir_in.push_back(mk(pfba_pkg::OP_ALLOC, 8191));
        dir_out.push_back(ow(0, pfba_pkg::ST_OK, 1, 1));
        dir_typed.push_back(1);
        dir_in.push_back(mk(pfba_pkg::OP_ALLOC, 0));
        dir_out.push_back(ow(1, pfba_pkg::ST_OK, 2, 1));
        dir_typed.push_back(1);
        dir_in.push_back(mk(pfba_pkg::OP_FREE, 8191));
        dir_out.push_back(ow(8191, pfba_pkg::ST_INVALID, 2, 1));
        dir_typed.push_back(1);
        dir_in.push_back(mk(pfba_pkg::OP_FREE, 2));
        dir_out.push_back(ow(2, pfba_pkg::ST_INVALID, 2, 1));
        dir_typed.push_back(1);
        dir_in.push_back(mk(pfba_pkg::OP_FREE, 1));
        dir_out.push_back(ow(1, pfba_pkg::ST_OK, 1, 1));
        dir_typed.push_back(1);
        dir_in.push_back(mk(pfba_pkg::OP_FREE, 1));
        dir_out.push_back(ow(1, pfba_pkg::ST_DOUBLE, 1, 1));
        dir_typed.push_back(1);
        dir_in.push_back(mk(pfba_pkg::OP_FREE, 0));
        dir_out.push_back(ow(0, pfba_pkg::ST_OK, 0, 1));
        dir_typed.push_back(1);
        foreach (dir_in[i]) send_word(dir_in[i], dir_typed[i], dir_out[i]);

        // one block per page: exhaust pages, free list reuse, out of memory
        drain_and_write(10'd0);
        for (int i = 0; i < 18; i++) send_word(mk(pfba_pkg::OP_ALLOC, 0), 0, '0);
        send_word(mk(pfba_pkg::OP_FREE, 3 * pfba_pkg::MAX_BLOCKS), 0, '0);
        send_word(mk(pfba_pkg::OP_FREE, 5 * pfba_pkg::MAX_BLOCKS), 0, '0);
        send_word(mk(pfba_pkg::OP_FREE, 5 * pfba_pkg::MAX_BLOCKS + 1), 0, '0);
        for (int i = 0; i < 3; i++) send_word(mk(pfba_pkg::OP_ALLOC, 0), 0, '0);

        // register above range, then run time lowering
        drain_and_write(10'd1023);
        for (int i = 0; i < 4; i++) send_word(mk(pfba_pkg::OP_ALLOC, 0), 0, '0);
        drain_and_write(10'd2);
        send_word(mk(pfba_pkg::OP_FREE, 3), 0, '0);
        send_word(mk(pfba_pkg::OP_ALLOC, 0), 0, '0);

        // random phases with varied sizes
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: drain_and_write(10'd1);
                1: drain_and_write(10'd512);
                2: drain_and_write(10'd3);
                default: drain_and_write(10'($urandom_range(1, 40)));
            endcase
            if (ph == 2) rx_hold = 1'b1;
            for (int i = 0; i < N_RANDOM / 8; i++) begin
                alloc_bias = (i < 60) ? 75 : 45;
                send_word(random_word(), 0, '0);
                gap_then_idle(short_or_long_gap());
            end
        end
        in_ch.valid = 1'b0;
        while (expected_words.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
`default_nettype wire
